// ===== rtl/slb_pkg.sv =====
`default_nettype none
package slb_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int STRIDE_W = 64;

  localparam logic signed [STRIDE_W-1:0] STRIDE_MIN = {1'b1, {(STRIDE_W-1){1'b0}}};
  localparam logic signed [STRIDE_W-1:0] NEG_INT64_MAX = {1'b1, {(STRIDE_W-2){1'b0}}, 1'b1};

  localparam logic ERR_OK = 1'b0;
  localparam logic ERR_ZERO_STRIDE = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/slb_div_stage.sv =====
`default_nettype none
// one quotient bit of a restoring division; nq holds the unused dividend
// bits on top and the quotient bits found so far at the bottom
module slb_div_stage #(
  parameter int LW = slb_pkg::LENGTH_BITS_DEF
) (
  input  wire  [LW-1:0] rem_i,
  input  wire  [LW-1:0] nq_i,
  input  wire  [LW-1:0] dvs_i,
  output logic [LW-1:0] rem_o,
  output logic [LW-1:0] nq_o
);

  logic [LW:0] trial;
  logic [LW:0] diff;
  logic        qbit;

  always_comb begin
    trial = {rem_i, nq_i[LW-1]};
    diff  = trial - {1'b0, dvs_i};
    qbit  = (trial >= {1'b0, dvs_i});
    rem_o = qbit ? diff[LW-1:0] : trial[LW-1:0];
    nq_o  = {nq_i[LW-2:0], qbit};
  end

endmodule
`default_nettype wire

// ===== rtl/slice_bounds_normalizer_unit.sv =====
`default_nettype none
// an input beat passes the stage a, stage b, divider and output registers
// throughput: one beat per cycle unless the result stalls; the element count
// comes from a divider with one pipeline stage per quotient bit
// a stalled result holds the whole pipeline, nothing is dropped
// reset (rst_n low, synchronous) clears all stage valid bits
module slice_bounds_normalizer_unit #(
  parameter int LENGTH_BITS = slb_pkg::LENGTH_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [LENGTH_BITS-1:0]           in_seq_length,
  input  wire  signed [63:0]               in_start_value,
  input  wire                              in_start_absent,
  input  wire  signed [63:0]               in_stop_value,
  input  wire                              in_stop_absent,
  input  wire  signed [63:0]               in_step_value,
  input  wire                              in_step_absent,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [LENGTH_BITS:0]      out_first_index,
  output logic signed [LENGTH_BITS:0]      out_end_index,
  output logic signed [63:0]               out_stride,
  output logic [LENGTH_BITS-1:0]           out_element_count,
  output logic                             out_error_code
);

  localparam int LW = LENGTH_BITS;
  localparam int IW = LW + 1;
  localparam int XW = 66;
  localparam int SW = slb_pkg::STRIDE_W;

  typedef struct packed {
    logic signed [IW-1:0] first;
    logic signed [IW-1:0] last;
    logic signed [SW-1:0] stride;
    logic                 err;
    logic                 cnt_zero;
    logic                 big;
  } side_t;

  logic en;
  logic out_valid_r;
  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  function automatic logic signed [XW-1:0] clamp_bound(
    input logic signed [XW-1:0] v,
    input logic signed [XW-1:0] len,
    input logic signed [XW-1:0] lo,
    input logic signed [XW-1:0] hi
  );
    logic signed [XW-1:0] t;
    t = (v < 0) ? v + len : v;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t;
  endfunction

  // stage a: stride fixup and bound clamping
  logic signed [SW-1:0] step_raw, step_e;
  logic                 neg_a, zero_a;
  logic signed [XW-1:0] len_x, lo_x, hi_x, first_x, last_x;

  always_comb begin
    step_raw = in_step_absent ? SW'(1) : in_step_value;
    step_e   = (step_raw == slb_pkg::STRIDE_MIN) ? slb_pkg::NEG_INT64_MAX : step_raw;
    neg_a    = step_e[SW-1];
    zero_a   = (step_e == '0);
    len_x    = XW'({1'b0, in_seq_length});
    lo_x     = neg_a ? -XW'(1) : '0;
    hi_x     = neg_a ? len_x - XW'(1) : len_x;
    if (in_start_absent) begin
      first_x = neg_a ? hi_x : lo_x;
    end else begin
      first_x = clamp_bound(XW'(in_start_value), len_x, lo_x, hi_x);
    end
    if (in_stop_absent) begin
      last_x = neg_a ? lo_x : hi_x;
    end else begin
      last_x = clamp_bound(XW'(in_stop_value), len_x, lo_x, hi_x);
    end
  end

  logic                 a_valid_r;
  logic signed [IW-1:0] a_first_r, a_last_r;
  logic signed [SW-1:0] a_stride_r;
  logic                 a_err_r, a_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
    if (en) begin
      a_first_r  <= zero_a ? '0 : first_x[IW-1:0];
      a_last_r   <= zero_a ? '0 : last_x[IW-1:0];
      a_stride_r <= step_e;
      a_err_r    <= zero_a ? slb_pkg::ERR_ZERO_STRIDE : slb_pkg::ERR_OK;
      a_neg_r    <= neg_a;
    end
  end

  // stage b: span and divisor
  logic signed [IW:0]   span_b;
  logic                 pos_b;
  logic [IW:0]          dvd_b;
  logic [SW-1:0]        mag_b;
  side_t                side_b;

  always_comb begin
    span_b = a_neg_r ? (IW+1)'(a_first_r) - (IW+1)'(a_last_r)
                     : (IW+1)'(a_last_r) - (IW+1)'(a_first_r);
    pos_b  = (span_b > 0);
    dvd_b  = pos_b ? (IW+1)'(span_b - (IW+1)'(1)) : '0;
    mag_b  = a_neg_r ? SW'(-a_stride_r) : SW'(a_stride_r);
    side_b.first    = a_first_r;
    side_b.last     = a_last_r;
    side_b.stride   = a_err_r ? '0 : a_stride_r;
    side_b.err      = a_err_r;
    side_b.cnt_zero = !pos_b || a_err_r;
    // a divisor beyond the dividend range gives quotient zero
    side_b.big      = ((mag_b >> LW) != '0);
  end

  logic          valid_r [0:LW];
  side_t         side_r  [0:LW];
  logic [LW-1:0] rem_r   [0:LW];
  logic [LW-1:0] nq_r    [0:LW];
  logic [LW-1:0] dvs_r   [0:LW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= a_valid_r;
    end
    if (en) begin
      side_r[0] <= side_b;
      rem_r[0]  <= '0;
      nq_r[0]   <= dvd_b[LW-1:0];
      dvs_r[0]  <= mag_b[LW-1:0];
    end
  end

  for (genvar i = 0; i < LW; i++) begin : g_div
    logic [LW-1:0] rem_nxt, nq_nxt;

    slb_div_stage #(.LW(LW)) u_stage (
      .rem_i (rem_r[i]),
      .nq_i  (nq_r[i]),
      .dvs_i (dvs_r[i]),
      .rem_o (rem_nxt),
      .nq_o  (nq_nxt)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
      end
      if (en) begin
        side_r[i+1] <= side_r[i];
        rem_r[i+1]  <= rem_nxt;
        nq_r[i+1]   <= nq_nxt;
        dvs_r[i+1]  <= dvs_r[i];
      end
    end
  end

  // output register
  side_t         fin;
  logic [LW-1:0] count_nxt;

  always_comb begin
    fin = side_r[LW];
    if (fin.cnt_zero) begin
      count_nxt = '0;
    end else if (fin.big) begin
      count_nxt = LW'(1);
    end else begin
      count_nxt = nq_r[LW] + LW'(1);
    end
  end

  logic signed [IW-1:0] out_first_r, out_last_r;
  logic signed [SW-1:0] out_stride_r;
  logic [LW-1:0]        out_count_r;
  logic                 out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[LW];
    end
    if (en) begin
      out_first_r  <= fin.first;
      out_last_r   <= fin.last;
      out_stride_r <= fin.stride;
      out_count_r  <= count_nxt;
      out_err_r    <= fin.err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_index   = out_first_r;
  assign out_end_index     = out_last_r;
  assign out_stride        = out_stride_r;
  assign out_element_count = out_count_r;
  assign out_error_code    = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> out_element_count == '0 && out_stride == '0)
    else $error("zero stride result carries nonzero count or stride");

  a_ok_stride: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_code |-> out_stride != '0)
    else $error("ok result with zero stride");

  a_count_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_count != '0 |-> out_first_index != out_end_index)
    else $error("nonzero count over an empty span");

endmodule
`default_nettype wire

// ===== verif/slice_bounds_normalizer_unit_tb.sv =====
`default_nettype none
module slice_bounds_normalizer_unit_tb;

  localparam int LB = 32;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [LB-1:0] seq_length;
    logic signed [63:0] start_value;
    logic start_absent;
    logic signed [63:0] stop_value;
    logic stop_absent;
    logic signed [63:0] step_value;
    logic step_absent;
  } slice_req_t;

  typedef struct packed {
    logic signed [LB:0] first_index;
    logic signed [LB:0] end_index;
    logic signed [63:0] stride;
    logic [LB-1:0] element_count;
    logic error_code;
  } slice_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire in_stall;
  logic [LB-1:0] in_seq_length = '0;
  logic signed [63:0] in_start_value = '0;
  logic in_start_absent = 1'b0;
  logic signed [63:0] in_stop_value = '0;
  logic in_stop_absent = 1'b0;
  logic signed [63:0] in_step_value = '0;
  logic in_step_absent = 1'b0;
  wire out_valid;
  logic out_stall = 1'b0;
  wire signed [LB:0] out_first_index;
  wire signed [LB:0] out_end_index;
  wire signed [63:0] out_stride;
  wire [LB-1:0] out_element_count;
  wire out_error_code;

  slice_req_t pending_reqs[$];
  slice_res_t expected_slices[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  int hold_start_cnt = 0;
  int results_seen = 0;
  int items_total = 0;

  slice_bounds_normalizer_unit #(.LENGTH_BITS(LB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_seq_length(in_seq_length),
    .in_start_value(in_start_value), .in_start_absent(in_start_absent),
    .in_stop_value(in_stop_value), .in_stop_absent(in_stop_absent),
    .in_step_value(in_step_value), .in_step_absent(in_step_absent),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_index(out_first_index), .out_end_index(out_end_index),
    .out_stride(out_stride), .out_element_count(out_element_count),
    .out_error_code(out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 128-bit signed math keeps offsets and spans free of overflow
  function automatic logic signed [127:0] clamp_index(logic signed [127:0] v,
      logic signed [127:0] len, logic signed [127:0] lo, logic signed [127:0] hi);
    if (v < 0) v = v + len;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic slice_res_t normalize_slice(slice_req_t r);
    slice_res_t res;
    logic signed [127:0] len, st, lo, hi, first, last, span, mag;
    res = '0;
    len = $signed({96'd0, r.seq_length});
    st = r.step_absent ? 128'sd1 : 128'(r.step_value);
    if (r.step_value == slb_pkg::STRIDE_MIN && !r.step_absent)
      st = 128'(slb_pkg::NEG_INT64_MAX);
    if (st == 0) begin
      res.error_code = slb_pkg::ERR_ZERO_STRIDE;
      return res;
    end
    lo = (st < 0) ? -128'sd1 : 128'sd0;
    hi = (st < 0) ? len - 1 : len;
    if (r.start_absent) first = (st < 0) ? hi : lo;
    else first = clamp_index(128'(r.start_value), len, lo, hi);
    if (r.stop_absent) last = (st < 0) ? lo : hi;
    else last = clamp_index(128'(r.stop_value), len, lo, hi);
    span = (st < 0) ? first - last : last - first;
    mag = (st < 0) ? -st : st;
    res.first_index = first[LB:0];
    res.end_index = last[LB:0];
    res.stride = st[63:0];
    res.element_count = (span > 0) ? LB'(1 + (span - 1) / mag) : '0;
    res.error_code = slb_pkg::ERR_OK;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [63:0] pick_bound(logic [LB-1:0] len);
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return $signed(64'($urandom_range(0, 40))) - 20;
      2: return 64'(len) + $signed(64'($urandom_range(0, 6))) - 3;
      3: return -64'(len) + $signed(64'($urandom_range(0, 6))) - 3;
      4: return $urandom_range(0, 1) ? slb_pkg::STRIDE_MIN : ~slb_pkg::STRIDE_MIN;
      default: return $signed(64'($urandom_range(0, 200))) - 100;
    endcase
  endfunction

  function automatic slice_req_t random_req();
    slice_req_t r;
    case ($urandom_range(0, 3))
      0: r.seq_length = $urandom;
      1: r.seq_length = $urandom_range(0, 3) == 0 ? '1 : LB'($urandom_range(0, 2));
      default: r.seq_length = $urandom_range(0, 100);
    endcase
    r.start_value = pick_bound(r.seq_length);
    r.stop_value = pick_bound(r.seq_length);
    case ($urandom_range(0, 5))
      0: r.step_value = {$urandom, $urandom};
      1: r.step_value = $urandom_range(0, 1) ? slb_pkg::STRIDE_MIN : slb_pkg::NEG_INT64_MAX;
      2: r.step_value = '0;
      default: r.step_value = $signed(64'($urandom_range(0, 20))) - 10;
    endcase
    r.start_absent = ($urandom_range(0, 4) == 0);
    r.stop_absent = ($urandom_range(0, 4) == 0);
    r.step_absent = ($urandom_range(0, 4) == 0);
    return r;
  endfunction

  function automatic slice_req_t make_req(logic [LB-1:0] len, logic signed [63:0] a,
      logic an, logic signed [63:0] b, logic bn, logic signed [63:0] s, logic sn);
    slice_req_t r;
    r.seq_length = len; r.start_value = a; r.start_absent = an;
    r.stop_value = b; r.stop_absent = bn; r.step_value = s; r.step_absent = sn;
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // driver
  always @(posedge clk) begin
    slice_req_t r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_slices.push_back(normalize_slice({in_seq_length, in_start_value,
          in_start_absent, in_stop_value, in_stop_absent, in_step_value, in_step_absent}));
        gap_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_seq_length <= r.seq_length;
          in_start_value <= r.start_value;
          in_start_absent <= r.start_absent;
          in_stop_value <= r.stop_value;
          in_stop_absent <= r.stop_absent;
          in_step_value <= r.step_value;
          in_step_absent <= r.step_absent;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    slice_res_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_slices.size() == 0) begin
          report_mismatch("unexpected result beat", 128'(out_element_count), '0);
        end else begin
          want = expected_slices.pop_front();
          if (out_error_code !== want.error_code)
            report_mismatch("error_code", out_error_code, want.error_code);
          if (out_first_index !== want.first_index)
            report_mismatch("first_index", out_first_index, want.first_index);
          if (out_end_index !== want.end_index)
            report_mismatch("end_index", out_end_index, want.end_index);
          if (out_stride !== want.stride)
            report_mismatch("stride", out_stride, want.stride);
          if (out_element_count !== want.element_count)
            report_mismatch("element_count", out_element_count, want.element_count);
        end
      end
      hold_start_cnt++;
      // one long hold-off so the pipeline fills and backs up the input
      if (hold_start_cnt == 300) hold_left = 150;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 1) == 0) hold_left = pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("FAIL slice_bounds_normalizer_unit");
        $finish;
      end
    end
  end

  initial begin
    pending_reqs.push_back(make_req(10, 0, 1, 0, 1, 0, 1));
    pending_reqs.push_back(make_req(10, 0, 1, 0, 1, -1, 0));
    pending_reqs.push_back(make_req(10, 2, 0, 8, 0, 0, 0));
    pending_reqs.push_back(make_req(10, 0, 1, 0, 1, slb_pkg::STRIDE_MIN, 0));
    pending_reqs.push_back(make_req(10, 9, 0, 0, 1, slb_pkg::NEG_INT64_MAX, 0));
    pending_reqs.push_back(make_req(10, -3, 0, -1, 0, 1, 0));
    pending_reqs.push_back(make_req(10, -30, 0, 30, 0, 3, 0));
    pending_reqs.push_back(make_req(10, 30, 0, -30, 0, -3, 0));
    pending_reqs.push_back(make_req(0, 0, 1, 0, 1, 1, 0));
    pending_reqs.push_back(make_req(0, 0, 1, 0, 1, -1, 0));
    pending_reqs.push_back(make_req('1, 0, 1, 0, 1, 1, 0));
    pending_reqs.push_back(make_req('1, 0, 1, 0, 1, -1, 0));
    pending_reqs.push_back(make_req('1, slb_pkg::STRIDE_MIN, 0, ~slb_pkg::STRIDE_MIN, 0, 7, 0));
    pending_reqs.push_back(make_req('1, ~slb_pkg::STRIDE_MIN, 0, slb_pkg::STRIDE_MIN, 0,
      slb_pkg::STRIDE_MIN, 0));
    pending_reqs.push_back(make_req('1, 0, 0, 0, 1, ~slb_pkg::STRIDE_MIN, 0));
    pending_reqs.push_back(make_req(5, 1, 0, 4, 0, '1, 1));
    pending_reqs.push_back(make_req(7, 5, 0, 5, 0, 2, 0));
    pending_reqs.push_back(make_req(1, 0, 0, 1, 0, 0, 0));
    for (int i = 0; i < 600; i++) pending_reqs.push_back(random_req());
    items_total = pending_reqs.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // every sent beat has to come back before the run can end
    wait (results_seen == items_total);
    repeat (LB + 10) @(posedge clk);
    if (errors == 0 && expected_slices.size() == 0) $display("PASS slice_bounds_normalizer_unit");
    else $display("FAIL slice_bounds_normalizer_unit");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/slb_pkg.sv
rtl/slb_div_stage.sv
rtl/slice_bounds_normalizer_unit.sv
verif/slice_bounds_normalizer_unit_tb.sv
